### sv/obng_pkg.sv
// Shared types, constants and constant functions of the oscillator bank noise generator.
// No dependencies; every other file of the block but obng_ram imports this package.
package obng_pkg;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SPACING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SEED   = 3'd4;

  // Register widths and reset values.
  localparam int COUNT_W = 9;
  localparam int PHASE_W = 32;
  localparam int GAIN_W  = 16;

  localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RST = 9'd240;
  localparam logic [PHASE_W-1:0] BASE_STEP_RST    = 32'd93495886;
  localparam logic [PHASE_W-1:0] STEP_SPACING_RST = 32'd81499;
  localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RST  = 16'd546;
  localparam logic [PHASE_W-1:0] LFSR_RST         = 32'd1;

  // Output sample format.
  localparam int SAMPLE_W   = 16;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int GAIN_SHIFT = 16;

  // Magnitude of a cosine table entry (0 .. 32767).
  localparam int COS_MAG_W = 15;

  // Fixed-point constants of the table generator.
  localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611B;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic start;     // begin a pass: clear the sum, load step and LFSR copy
    logic init;      // pass is the phase load after reset, no sample produced
    logic issue;     // read the oscillator at the current index
    logic last;      // current index is the last oscillator
    logic mul;       // multiply the finished sum by the gain
    logic load_out;  // saturate and load the output register
  } ctrl_cmd_t;

  // One step of the 32-bit xorshift generator.
  function automatic logic [PHASE_W-1:0] lfsr_next(input logic [PHASE_W-1:0] x);
    logic [PHASE_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // (a * b) >> 62 for Q62 operands whose product is below 4.0.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // One Horner step of the cosine series: 1 - p, floored at zero.
  function automatic logic [63:0] taylor_fold(input logic [63:0] p);
    return (p >= Q62_ONE) ? 64'd0 : Q62_ONE - p;
  endfunction

  // Rounded magnitude of 32767 * cos(pi/2 * m / 2^(tbits-2)), m in 0 .. 2^(tbits-2).
  // Evaluated at elaboration only, to fill the quarter-wave table.
  function automatic logic [COS_MAG_W-1:0] quarter_cos_mag(input int unsigned m,
                                                           input int unsigned tbits);
    logic [63:0] frac;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    frac = 64'(m) << (64 - tbits);
    x    = mul_q62(HALF_PI_Q62, frac);
    x2   = mul_q62(x, x);
    t    = Q62_ONE;
    t    = taylor_fold(mul_q62(x2, t) / 64'd650);
    t    = taylor_fold(mul_q62(x2, t) / 64'd552);
    t    = taylor_fold(mul_q62(x2, t) / 64'd462);
    t    = taylor_fold(mul_q62(x2, t) / 64'd380);
    t    = taylor_fold(mul_q62(x2, t) / 64'd306);
    t    = taylor_fold(mul_q62(x2, t) / 64'd240);
    t    = taylor_fold(mul_q62(x2, t) / 64'd182);
    t    = taylor_fold(mul_q62(x2, t) / 64'd132);
    t    = taylor_fold(mul_q62(x2, t) / 64'd90);
    t    = taylor_fold(mul_q62(x2, t) / 64'd56);
    t    = taylor_fold(mul_q62(x2, t) / 64'd30);
    t    = taylor_fold(mul_q62(x2, t) / 64'd12);
    t    = taylor_fold(mul_q62(x2, t) / 64'd2);
    v    = (((t >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
    return v[COS_MAG_W-1:0];
  endfunction

endpackage

### sv/obng_if.sv
// Handshake channels of the oscillator bank noise generator: tick input, sample output
// and configuration writes. Depends on obng_pkg for the payload widths.
interface obng_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface obng_sample_if
  import obng_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       clipped;

  modport source (output valid, output sample, output clipped, input ready);
  modport sink   (input valid, input sample, input clipped, output ready);
endinterface

interface obng_cfg_if
  import obng_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/obng_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module obng_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/obng_ctrl.sv
// Sequencer of the oscillator bank noise generator: phase load after reset, one pass
// over the bank per tick, multiply and output handoff. Depends on obng_pkg.
module obng_ctrl
  import obng_pkg::*;
#(
  parameter int NUM_OSC = 256
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output ctrl_cmd_t                                  cmd_o,
  output logic [$clog2(NUM_OSC > 1 ? NUM_OSC : 2)-1:0] idx_o
);

  localparam int IDX_W = $clog2(NUM_OSC > 1 ? NUM_OSC : 2);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_OSC - 1);

  localparam logic [2:0] ST_BOOT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // The datapath has three stages behind the read issue.
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       drain_q, drain_d;
  logic             init_q, init_d;
  logic             out_valid_q, out_valid_d;
  ctrl_cmd_t        cmd;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    drain_d     = drain_q;
    init_d      = init_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_BOOT: begin
        cmd.start = 1'b1;
        cmd.init  = 1'b1;
        init_d    = 1'b1;
        idx_d     = '0;
        state_d   = ST_RUN;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.start = 1'b1;
          init_d    = 1'b0;
          idx_d     = '0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cmd.last  = (idx_q == IDX_LAST);
        if (idx_q == IDX_LAST) begin
          drain_d = '0;
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == DRAIN_LAST) begin
          state_d = init_q ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOOT;
      idx_q       <= '0;
      drain_q     <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      drain_q     <= drain_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign idx_o       = idx_q;
  assign out_valid_o = out_valid_q;

endmodule

### sv/obng_dp.sv
// Datapath of the oscillator bank noise generator: configuration registers, LFSR,
// phase memory, cosine lookup, accumulator, gain multiplier and saturation.
// Depends on obng_pkg and obng_ram.
module obng_dp
  import obng_pkg::*;
#(
  parameter int NUM_OSC    = 256,
  parameter int TABLE_BITS = 10
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  ctrl_cmd_t                                  cmd_i,
  input  logic [$clog2(NUM_OSC > 1 ? NUM_OSC : 2)-1:0] idx_i,
  input  logic                                       restart_i,
  input  logic                                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                      cfg_data_i,
  output logic signed [SAMPLE_W-1:0]                 sample_o,
  output logic                                       clipped_o
);

  localparam int IDX_W   = $clog2(NUM_OSC > 1 ? NUM_OSC : 2);
  localparam int CMP_W   = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int M_W     = TABLE_BITS - 1;
  localparam int ACC_W   = COS_MAG_W + 1 + $clog2(NUM_OSC > 1 ? NUM_OSC : 2);
  localparam int PROD_W  = ACC_W + GAIN_W + 1;
  localparam int RES_W   = PROD_W - GAIN_SHIFT;

  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(SAMPLE_MAX);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(SAMPLE_MIN);

  // Configuration registers.
  logic [COUNT_W-1:0] active_count_q;
  logic [PHASE_W-1:0] base_step_q;
  logic [PHASE_W-1:0] step_spacing_q;
  logic [GAIN_W-1:0]  output_gain_q;

  // LFSR state and the running copy used during a reload pass.
  logic [PHASE_W-1:0] lfsr_q;
  logic [PHASE_W-1:0] wk_q;
  logic [PHASE_W-1:0] lfsr_nx;
  logic               seed_written_q;
  logic               seed_we;
  logic [PHASE_W-1:0] seed_val;

  logic               restart_q;
  logic               init_q;
  logic [PHASE_W-1:0] step_q;

  // Stage 1: phase update.
  logic               s1_valid_q;
  logic               s1_active_q;
  logic [IDX_W-1:0]   s1_idx_q;
  logic [PHASE_W-1:0] s1_lfsr_q;
  logic [PHASE_W-1:0] s1_step_q;
  logic [PHASE_W-1:0] ram_rdata;
  logic [PHASE_W-1:0] phase_base;
  logic [PHASE_W-1:0] phase_new;
  logic               ram_we;
  logic               active0;

  // Stage 2: quarter-wave fold and table lookup.
  logic                  s2_en_q;
  logic [TABLE_BITS-1:0] s2_key_q;
  logic [1:0]            quad;
  logic [M_W-1:0]        fold_idx;
  logic [COS_MAG_W-1:0]  qrom [QUARTER+1];

  // Stage 3: accumulate.
  logic                     s3_en_q;
  logic                     s3_neg_q;
  logic [COS_MAG_W-1:0]     s3_mag_q;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [RES_W-1:0]  res;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                     clipped_q;

  // Configuration writes. A seed of zero would lock the LFSR, so it loads as one.
  assign seed_we  = cfg_we_i && (cfg_index_i == REG_PHASE_SEED);
  assign seed_val = (cfg_data_i == '0) ? PHASE_W'(1) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= ACTIVE_COUNT_RST;
      base_step_q    <= BASE_STEP_RST;
      step_spacing_q <= STEP_SPACING_RST;
      output_gain_q  <= OUTPUT_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ACTIVE_COUNT: active_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_BASE_STEP:    base_step_q    <= cfg_data_i[PHASE_W-1:0];
        REG_STEP_SPACING: step_spacing_q <= cfg_data_i[PHASE_W-1:0];
        REG_OUTPUT_GAIN:  output_gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign lfsr_nx = lfsr_next(wk_q);

  // The pass works on a copy. After a reload pass the copy becomes the LFSR state unless
  // a seed was written while the pass ran, since that write logically comes afterwards.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q         <= LFSR_RST;
      seed_written_q <= 1'b0;
      restart_q      <= 1'b0;
      init_q         <= 1'b0;
    end else begin
      if (seed_we) begin
        lfsr_q <= seed_val;
      end else if (cmd_i.issue && cmd_i.last && restart_q && !seed_written_q) begin
        lfsr_q <= lfsr_nx;
      end
      if (seed_we) begin
        seed_written_q <= 1'b1;
      end else if (cmd_i.start) begin
        seed_written_q <= 1'b0;
      end
      if (cmd_i.start) begin
        restart_q <= cmd_i.init | restart_i;
        init_q    <= cmd_i.init;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wk_q   <= lfsr_q;
      step_q <= base_step_q;
    end else if (cmd_i.issue) begin
      step_q <= step_q + step_spacing_q;
      if (restart_q) begin
        wk_q <= lfsr_nx;
      end
    end
  end

  // Stage 0: issue the read of one oscillator's phase.
  assign active0 = !init_q && (CMP_W'(idx_i) < CMP_W'(active_count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_en_q    <= 1'b0;
      s3_en_q    <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_en_q    <= s1_valid_q && s1_active_q;
      s3_en_q    <= s2_en_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_active_q <= active0;
    s1_idx_q    <= idx_i;
    s1_lfsr_q   <= lfsr_nx;
    s1_step_q   <= step_q;
  end

  obng_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (NUM_OSC)
  ) u_phase_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (phase_new),
    .rd_en_i   (cmd_i.issue),
    .rd_addr_i (idx_i),
    .rd_data_o (ram_rdata)
  );

  // Stage 1: a restart replaces the stored phase by the fresh random value.
  assign phase_base = restart_q ? s1_lfsr_q : ram_rdata;
  assign phase_new  = phase_base + (s1_active_q ? s1_step_q : '0);
  assign ram_we     = s1_valid_q && (restart_q || s1_active_q);

  always_ff @(posedge clk_i) begin
    s2_key_q <= phase_new[PHASE_W-1 -: TABLE_BITS];
  end

  // Stage 2: quadrants one and three mirror the index, quadrants one and two negate.
  for (genvar g = 0; g <= QUARTER; g++) begin : g_qrom
    localparam logic [COS_MAG_W-1:0] Entry = quarter_cos_mag(g, TABLE_BITS);
    assign qrom[g] = Entry;
  end

  assign quad     = s2_key_q[TABLE_BITS-1 -: 2];
  assign fold_idx = quad[0] ? (M_W'(QUARTER) - {1'b0, s2_key_q[TABLE_BITS-3:0]})
                            : {1'b0, s2_key_q[TABLE_BITS-3:0]};

  always_ff @(posedge clk_i) begin
    s3_mag_q <= qrom[fold_idx];
    s3_neg_q <= quad[0] ^ quad[1];
  end

  // Stage 3: accumulate the signed cosine values.
  assign term = s3_neg_q ? -$signed({{(ACC_W - COS_MAG_W){1'b0}}, s3_mag_q})
                         :  $signed({{(ACC_W - COS_MAG_W){1'b0}}, s3_mag_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (s3_en_q) begin
      acc_q <= acc_q + term;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'($signed({1'b0, output_gain_q}));
    end
  end

  // The arithmetic shift floors toward minus infinity, then the result saturates.
  assign res = $signed(prod_q[PROD_W-1:GAIN_SHIFT]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      priority if (res > RES_MAX) begin
        sample_q  <= SAMPLE_W'(SAMPLE_MAX);
        clipped_q <= 1'b1;
      end else if (res < RES_MIN) begin
        sample_q  <= SAMPLE_W'(SAMPLE_MIN);
        clipped_q <= 1'b1;
      end else begin
        sample_q  <= res[SAMPLE_W-1:0];
        clipped_q <= 1'b0;
      end
    end
  end

  assign sample_o  = sample_q;
  assign clipped_o = clipped_q;

endmodule

### sv/oscillator_bank_noise_generator_core.sv
// Top level of the oscillator bank noise generator: sequencer, datapath and channels.
// Depends on obng_pkg, obng_if, obng_ctrl and obng_dp.
//
// Usage. Every request on item_i is one sample tick. With restart low, the first
// active_count oscillators advance their phases by base_step plus index times
// step_spacing, their cosines are summed, scaled by output_gain / 2^16 and saturated
// into one Q1.15 sample on sample_o, with clipped set when the scaled sum was clamped.
// With restart high, every phase in the bank is first reloaded from the xorshift LFSR
// and then stepped in the same pass. cfg_i writes registers by index (0 active count,
// 1 base step, 2 step spacing, 3 output gain, 4 phase seed); it is always ready.
//
// Sequence. A tick walks the phase memory one oscillator per cycle, reading and
// updating phases; the sequencer then drains the lookup pipeline, runs the gain
// multiplier and loads the output register. The next request is taken only once the
// sequencer is back in idle after that load.
//
// Reset loads every phase from the LFSR with the reset seed; item_i is not ready during
// this pass. A stalled sample_o keeps its sample; a new tick may still be accepted and
// run, and its result waits until the old one is taken.
module oscillator_bank_noise_generator_core
  import obng_pkg::*;
#(
  parameter int NUM_OSC    = 256,
  parameter int TABLE_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  obng_tick_if.sink     item_i,
  obng_sample_if.source sample_o,
  obng_cfg_if.sink      cfg_i
);

  localparam int IDX_W = $clog2(NUM_OSC > 1 ? NUM_OSC : 2);

  ctrl_cmd_t        cmd;
  logic [IDX_W-1:0] idx;
  logic             in_ready;
  logic             out_valid;

  // Configuration writes land in the datapath registers in the cycle they arrive.
  assign cfg_i.ready = 1'b1;

  obng_ctrl #(
    .NUM_OSC (NUM_OSC)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (sample_o.ready),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  obng_dp #(
    .NUM_OSC    (NUM_OSC),
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .restart_i   (item_i.restart),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .sample_o    (sample_o.sample),
    .clipped_o   (sample_o.clipped)
  );

  assign item_i.ready   = in_ready;
  assign sample_o.valid = out_valid;

  // Once a tick is taken the bank is busy walking its phases.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("tick accepted while the previous pass was still starting");

  // Loading the output register always presents a sample.
  a_load_shows_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> sample_o.valid)
    else $error("loaded sample not presented");

  // A clamped sample sits at one of the two rails.
  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_o.valid && sample_o.clipped |->
      (sample_o.sample == 16'sh7FFF) || (sample_o.sample == 16'sh8000))
    else $error("clipped flag set on a sample inside the range");

endmodule

### tb/tb.sv
// Self-checking testbench of oscillator_bank_noise_generator_core: a bit-exact bank model
// predicts every sample, with random idling on the tick and sample channels.
// Depends on obng_pkg, the channel interfaces in obng_if and the core itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obng_pkg::*;

  localparam int NUM_OSC      = 256;
  localparam int TABLE_BITS   = 10;
  localparam int TABLE_SIZE   = 1 << TABLE_BITS;
  localparam int QUARTER_SIZE = 1 << (TABLE_BITS - 2);
  localparam int SERIES_TERMS = 13;
  localparam int RANDOM_TICKS = 1700;
  // A tick holds the block for one pass over the bank; with the longest sender gap and the
  // longest receiver stall on top, no quiet stretch of a correct run comes near this.
  localparam int QUIET_LIMIT  = 8000;

  localparam logic [63:0] UNIT_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_QQ62 = 64'h6487_ED51_10B4_611B;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } sample_t;

  logic clk;
  logic rst_n;

  obng_tick_if   tick_ch ();
  obng_sample_if sample_ch ();
  obng_cfg_if    cfg_ch ();

  oscillator_bank_noise_generator_core #(
    .NUM_OSC   (NUM_OSC),
    .TABLE_BITS(TABLE_BITS)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (tick_ch),
    .sample_o(sample_ch),
    .cfg_i   (cfg_ch)
  );

  // Model of the bank: its registers, the phase memory, the xorshift word and the
  // cosine ROM. The ROM is filled once at time zero.
  logic [COUNT_W-1:0] cur_active;
  logic [PHASE_W-1:0] cur_base;
  logic [PHASE_W-1:0] cur_spacing;
  logic [GAIN_W-1:0]  cur_gain;
  logic [PHASE_W-1:0] prng_word;
  logic [PHASE_W-1:0] bank_phase [NUM_OSC];
  int                 cos_rom [TABLE_SIZE];

  // Restart flags waiting for the driver, and samples the model expects, oldest first.
  bit      tick_backlog [$];
  sample_t pending_samples [$];

  int ticks_queued;
  int ticks_taken;
  int errors;
  int quiet_cycles;
  bit src_jitter;
  bit snk_jitter;
  int gap_left;
  int stall_left;

  // Full 128-bit product of two Q62 numbers, brought back to Q62.
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = 128'(a) * 128'(b);
    return 64'(full >> 62);
  endfunction

  // Idle lengths: mostly none or a few cycles, now and then most of a tick or longer.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    else if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 280);
    else return $urandom_range(281, 600);
  endfunction

  // Every phase of the bank is reloaded in order, each from the next xorshift word.
  function automatic void reseed_phases();
    int n;
    for (n = 0; n < NUM_OSC; n++) begin
      prng_word = prng_word ^ (prng_word << 13);
      prng_word = prng_word ^ (prng_word >> 17);
      prng_word = prng_word ^ (prng_word << 5);
      bank_phase[n] = prng_word;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ACTIVE_COUNT: cur_active = val[COUNT_W-1:0];
      REG_BASE_STEP:    cur_base = val;
      REG_STEP_SPACING: cur_spacing = val;
      REG_OUTPUT_GAIN:  cur_gain = val[GAIN_W-1:0];
      // A zero seed would lock the xorshift at zero, so it is taken as one.
      REG_PHASE_SEED:   prng_word = (val == '0) ? PHASE_W'(1) : val;
      default: ;
    endcase
  endfunction

  // One tick of the bank: optional reload, phase advance, cosine sum, gain and clamp.
  function automatic void advance_bank(input logic restart);
    int          count;
    int          i;
    logic [31:0] inc;
    longint      sum;
    longint      level;
    sample_t     res;
    if (restart) reseed_phases();
    count = (cur_active > NUM_OSC) ? NUM_OSC : int'(cur_active);
    inc   = cur_base;
    sum   = 0;
    for (i = 0; i < count; i++) begin
      bank_phase[i] = bank_phase[i] + inc;
      sum = sum + cos_rom[bank_phase[i][PHASE_W-1 -: TABLE_BITS]];
      inc = inc + cur_spacing;
    end
    // The arithmetic shift floors, so negative sums round toward minus infinity.
    level = (sum * longint'(cur_gain)) >>> GAIN_SHIFT;
    res.clipped = 1'b0;
    if (level > SAMPLE_MAX) begin
      level = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (level < SAMPLE_MIN) begin
      level = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample = level[SAMPLE_W-1:0];
    pending_samples.push_back(res);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Tick driver. A request stays up until the block takes it; the gap drawn with it
  // runs from its acceptance, so the next request rises at any point of the pass.
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        advance_bank(tick_ch.restart);
        ticks_taken++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (gap_left > 0) begin
          tick_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (tick_backlog.size() > 0) begin
          tick_ch.valid <= 1'b1;
          tick_ch.restart <= tick_backlog.pop_front();
          gap_left <= src_jitter ? pick_gap() : 0;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Sample monitor. Every accepted sample is held against the oldest prediction, field
  // by field; ready drops now and then for a random stretch.
  always @(posedge clk) begin : sample_monitor
    sample_t want;
    if (!rst_n) begin
      sample_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        if (pending_samples.size() == 0) begin
          $display("%0t ns: sample with no tick behind it, expected none, actual %0d/%0b",
                   $time, sample_ch.sample, sample_ch.clipped);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (sample_ch.sample !== want.sample) begin
            $display("%0t ns: sample mismatch, expected %0d, actual %0d",
                     $time, want.sample, sample_ch.sample);
            errors++;
          end
          if (sample_ch.clipped !== want.clipped) begin
            $display("%0t ns: clipped mismatch, expected %0b, actual %0b",
                     $time, want.clipped, sample_ch.clipped);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        sample_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        sample_ch.ready <= 1'b1;
        if (snk_jitter && $urandom_range(0, 99) == 0) stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: any accepted request on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("oscillator_bank_noise_generator_core verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Register write over the configuration channel; the model follows on acceptance.
  // Writes are issued only while the bank is idle, so no tick sees a half-done setting.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic queue_tick(input bit restart);
    tick_backlog.push_back(restart);
    ticks_queued++;
  endtask

  // Holds the sender off until every queued tick was taken and its sample has come.
  // Each phase ends this way, which also gives the bank a fully drained pause.
  task automatic drain();
    @(posedge clk);
    while (ticks_taken != ticks_queued || pending_samples.size() != 0) @(posedge clk);
  endtask

  // Random setting for one phase. The active count favors the legal range but also
  // visits zero, the bank size and counts beyond it; data bits above a register's
  // width are sometimes set to show that they are ignored.
  task automatic random_setting();
    logic [CFG_DATA_W-1:0] upper;
    int                    r;
    int                    idx;
    upper = ($urandom_range(0, 1) == 1) ? $urandom : '0;
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      write_reg(REG_ACTIVE_COUNT, (r == 0) ? (upper & ~32'h1FF) :
                                  (r == 1) ? 32'd1 :
                                  (r == 2) ? NUM_OSC :
                                  (r == 3) ? $urandom_range(NUM_OSC + 1, 511) :
                                             $urandom_range(1, NUM_OSC));
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      write_reg(REG_BASE_STEP, (r == 0) ? '0 : (r == 1) ? '1 : $urandom);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      write_reg(REG_STEP_SPACING, (r == 0) ? '0 : (r == 1) ? '1 :
                                  (r < 5) ? $urandom_range(0, 1 << 20) : $urandom);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 9);
      write_reg(REG_OUTPUT_GAIN, (upper & ~32'hFFFF) | ((r == 0) ? 32'd0 :
                                 (r == 1) ? 32'hFFFF :
                                 (r < 6) ? $urandom_range(0, 1023) :
                                           $urandom_range(0, 65535)));
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_PHASE_SEED, ($urandom_range(0, 5) == 0) ? '0 : $urandom);
    if ($urandom_range(0, 7) == 0) begin
      idx = $urandom_range(REG_PHASE_SEED + 1, (1 << CFG_IDX_W) - 1);
      write_reg(CFG_IDX_W'(idx), $urandom);
    end
  endtask

  initial begin : stimulus
    int          k;
    int          j;
    int          quad;
    int          m;
    int          idx;
    int          n;
    int          random_ticks;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] mag;

    // Every input is at a known level before the first edge.
    rst_n           = 1'b0;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    sample_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    ticks_queued    = 0;
    ticks_taken     = 0;
    errors          = 0;
    quiet_cycles    = 0;
    src_jitter      = 1'b1;
    snk_jitter      = 1'b1;

    // Cosine ROM by quarter-wave symmetry. The first quadrant is a Q62 Taylor series
    // in Horner form, floored at zero at each step, then scaled to 32767 and rounded.
    for (k = 0; k < TABLE_SIZE; k++) begin
      quad = k >> (TABLE_BITS - 2);
      m = k % QUARTER_SIZE;
      if (quad == 1 || quad == 3) m = QUARTER_SIZE - m;
      x  = q62_mul(HALF_PI_QQ62, 64'(m) << (64 - TABLE_BITS));
      x2 = q62_mul(x, x);
      t  = UNIT_Q62;
      for (j = SERIES_TERMS; j >= 1; j--) begin
        p = q62_mul(x2, t) / 64'((2 * j - 1) * (2 * j));
        t = (p >= UNIT_Q62) ? 64'd0 : UNIT_Q62 - p;
      end
      mag = ((t >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
      cos_rom[k] = (quad == 1 || quad == 2) ? -int'(mag) : int'(mag);
    end

    // Reset state of the model: default registers and a phase load from the reset seed,
    // just as the block does in its clearing pass after reset.
    cur_active  = ACTIVE_COUNT_RST;
    cur_base    = BASE_STEP_RST;
    cur_spacing = STEP_SPACING_RST;
    cur_gain    = OUTPUT_GAIN_RST;
    prng_word   = 32'd1;
    reseed_phases();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: plain ticks straight after the phase load, then a restart and another plain tick.
    // The driver simply waits for the block to leave its clearing pass.
    queue_tick(1'b0);
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b0);
    drain();

    // No active oscillator: the sum is empty and the phases hold but for the restart reload.
    write_reg(REG_ACTIVE_COUNT, '0);
    queue_tick(1'b0);
    queue_tick(1'b1);
    drain();

    // Count far above the bank, frozen phases and full gain: the sum saturates.
    write_reg(REG_ACTIVE_COUNT, 32'h1FF);
    write_reg(REG_BASE_STEP, '0);
    write_reg(REG_STEP_SPACING, '0);
    write_reg(REG_OUTPUT_GAIN, 32'hFFFF);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    drain();

    // Zero seed, and all-ones steps so that every increment wraps around the turn.
    write_reg(REG_PHASE_SEED, '0);
    write_reg(REG_BASE_STEP, '1);
    write_reg(REG_STEP_SPACING, '1);
    write_reg(REG_ACTIVE_COUNT, NUM_OSC + 1);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    drain();

    // One oscillator at unit gain: negative sums must floor to -1, not truncate to 0.
    write_reg(REG_ACTIVE_COUNT, 32'd1);
    write_reg(REG_OUTPUT_GAIN, 32'd1);
    write_reg(REG_BASE_STEP, 32'h4000_0000);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b0);
    drain();

    // Whole bank with an all-ones seed and the reset gain.
    write_reg(REG_ACTIVE_COUNT, NUM_OSC);
    write_reg(REG_PHASE_SEED, '1);
    write_reg(REG_OUTPUT_GAIN, OUTPUT_GAIN_RST);
    write_reg(REG_STEP_SPACING, STEP_SPACING_RST);
    queue_tick(1'b1);
    queue_tick(1'b0);
    drain();

    // Writes to unused indexes change nothing; zero gain silences the bank.
    for (idx = REG_PHASE_SEED + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), $urandom);
    write_reg(REG_OUTPUT_GAIN, '0);
    queue_tick(1'b0);
    queue_tick(1'b1);
    drain();

    // Random phases: a new setting, a burst of ticks with occasional restarts, then a
    // full drain. Some phases run a side without idling at all.
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      src_jitter = ($urandom_range(0, 3) != 0);
      snk_jitter = ($urandom_range(0, 3) != 0);
      random_setting();
      n = $urandom_range(60, 140);
      repeat (n) queue_tick($urandom_range(0, 7) == 0);
      random_ticks += n;
      drain();
    end

    // Let a stray extra sample show up before the verdict.
    repeat (NUM_OSC + 16) @(posedge clk);
    if (errors == 0) begin
      $display("oscillator_bank_noise_generator_core verification clean");
    end else begin
      $display("oscillator_bank_noise_generator_core verification failed");
    end
    $finish;
  end

endmodule
